FILE: hdl/snos_pkg.sv
// shared types and constants for the sphere node overlap search unit
// no dependencies; imported by every module of the block
`default_nettype none

package snos_pkg;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int RSUM_W   = RADIUS_W + 1;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;
    localparam int POS_W    = 3 * COORD_W;
    localparam int DIFF_W   = COORD_W + 2;
    localparam int MAG_W    = COORD_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int CFG_W    = RADIUS_W;
    localparam int NODES_DEF = 256;

    // item op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic REG_NODE_RADIUS = 1'b0;
    localparam logic REG_NODE_COUNT  = 1'b1;

    // control word for the shared square and accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
        logic limit_load;
    } sq_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/snos_node_mem.sv
// node position memory: one write port, one registered read port
// uses snos_pkg for the entry width
`default_nettype none

module snos_node_mem
    import snos_pkg::*;
#(
    parameter int DEPTH  = NODES_DEF,
    parameter int ADDR_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [POS_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [POS_W-1:0]  rd_data
);

    logic [POS_W-1:0] mem [0:DEPTH-1];
    logic [POS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hdl/snos_sq_unit.sv
// shared square and accumulate unit: |a - b| squared, running sum, limit compare
// uses snos_pkg for widths and the control struct
`default_nettype none

module snos_sq_unit
    import snos_pkg::*;
(
    input  wire logic                     clk,
    input  wire sq_ctrl_t                 ctrl,
    input  wire logic signed [MAG_W-1:0]  opa,
    input  wire logic signed [MAG_W-1:0]  opb,
    output logic                          in_reach
);

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] diff_neg;
    logic        [MAG_W-1:0]  mag;
    logic        [SQ_W-1:0]   sq;
    logic        [SQ_W-1:0]   sum;
    logic        [SQ_W-1:0]   prod_reg;
    logic        [SQ_W-1:0]   acc_reg;
    logic        [SQ_W-1:0]   limit_reg;

    assign diff     = DIFF_W'(opa) - DIFF_W'(opb);
    assign diff_neg = -diff;
    assign mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
    assign sq       = mag * mag;

    // three squares stay below 2^50, so the sum cannot wrap
    assign sum      = acc_reg + prod_reg;
    assign in_reach = (sum <= limit_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= sq;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= sum;
        end
        if (ctrl.limit_load)
        begin
            limit_reg <= prod_reg;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sphere_node_overlap_search_unit.sv
// top level of the sphere node overlap search: sequencer, config registers
// depends on snos_pkg, snos_node_mem and snos_sq_unit
`default_nettype none

// usage
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   node_radius, index 1 is node_count. cfg_ready is always high; write only
//   while busy is low.
//   item channel: an item is taken on a rising edge with start high and busy low.
//   op = write stores pos_x/y/z at index (ignored when index >= node count) and
//   busy stays low, no result.
//   op = query searches nodes from 0 upward; the result shows on hit and
//   node_index for exactly one cycle with done high.
//   sequencing: one shared 25x25 squarer handles x, y and z of one node in turn,
//   then the summed squares are compared with the squared radius sum. busy drops
//   the cycle after done.
//   results cannot be stalled: the receiver takes each one while done is high.
//   reset: node_radius and node_count clear to zero, the sequencer goes idle;
//   node positions keep no reset value and must be written before use.
module sphere_node_overlap_search_unit
    import snos_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                op,
    input  wire logic [INDEX_W-1:0]  index,
    input  wire logic [COORD_W-1:0]  pos_x,
    input  wire logic [COORD_W-1:0]  pos_y,
    input  wire logic [COORD_W-1:0]  pos_z,
    input  wire logic [RADIUS_W-1:0] probe_radius,
    output logic                     done,
    output logic                     hit,
    output logic [INDEX_W-1:0]       node_index,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int USED_W = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LIM  = 8'b0000_0010,
        S_LIMW = 8'b0000_0100,
        S_SQX  = 8'b0000_1000,
        S_SQY  = 8'b0001_0000,
        S_SQZ  = 8'b0010_0000,
        S_CMP  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [RADIUS_W-1:0]   node_radius_reg;
    logic [COUNT_W-1:0]    node_count_reg;
    logic [ADDR_W-1:0]     i_reg, i_next;
    logic [COORD_W-1:0]    px_reg, py_reg, pz_reg;
    logic [RSUM_W-1:0]     rsum_reg;
    logic                  hit_reg, hit_next;
    logic [INDEX_W-1:0]    node_index_reg, node_index_next;

    logic [USED_W-1:0]     used;
    logic                  accept;
    logic                  wr_en;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [POS_W-1:0]      rd_data;
    logic                  last_node;
    logic                  in_reach;
    sq_ctrl_t              sq_ctrl;
    logic signed [MAG_W-1:0] opa, opb;

    // node_count above the table depth acts as the depth
    assign used = (USED_W'(node_count_reg) > USED_W'(NODES))
                ? USED_W'(NODES) : USED_W'(node_count_reg);

    assign accept    = start && !busy;
    assign wr_en     = accept && (op == OP_WRITE) && (USED_W'(index) < used);
    assign last_node = ((USED_W'(i_reg) + USED_W'(1)) == used);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done       = (state_reg == S_OUT);
    assign hit        = hit_reg;
    assign node_index = node_index_reg;

    snos_node_mem #(
        .DEPTH  (NODES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(index)),
        .wr_data ({pos_z, pos_y, pos_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    snos_sq_unit u_sq (
        .clk      (clk),
        .ctrl     (sq_ctrl),
        .opa      (opa),
        .opb      (opb),
        .in_reach (in_reach)
    );

    // operand select for the shared squarer
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                opa = MAG_W'($signed(rd_data[COORD_W-1:0]));
                opb = MAG_W'($signed(px_reg));
            end
            S_SQY:
            begin
                opa = MAG_W'($signed(rd_data[2*COORD_W-1:COORD_W]));
                opb = MAG_W'($signed(py_reg));
            end
            S_SQZ:
            begin
                opa = MAG_W'($signed(rd_data[3*COORD_W-1:2*COORD_W]));
                opb = MAG_W'($signed(pz_reg));
            end
            default:
            begin
                opa = $signed({1'b0, rsum_reg});
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        hit_next        = hit_reg;
        node_index_next = node_index_reg;
        rd_en           = 1'b0;
        rd_addr         = i_reg;
        sq_ctrl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_QUERY))
                begin
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                // square the radius sum and fetch node 0
                sq_ctrl.mul_en = 1'b1;
                i_next         = '0;
                rd_en          = 1'b1;
                rd_addr        = '0;
                state_next     = S_LIMW;
            end
            S_LIMW:
            begin
                sq_ctrl.limit_load = 1'b1;
                if (used == '0)
                begin
                    hit_next        = 1'b0;
                    node_index_next = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                sq_ctrl.mul_en = 1'b1;
                state_next     = S_SQY;
            end
            S_SQY:
            begin
                sq_ctrl.mul_en   = 1'b1;
                sq_ctrl.acc_load = 1'b1;
                state_next       = S_SQZ;
            end
            S_SQZ:
            begin
                sq_ctrl.mul_en  = 1'b1;
                sq_ctrl.acc_add = 1'b1;
                state_next      = S_CMP;
            end
            S_CMP:
            begin
                if (in_reach)
                begin
                    hit_next        = 1'b1;
                    node_index_next = INDEX_W'(i_reg);
                    state_next      = S_OUT;
                end
                else if (last_node)
                begin
                    hit_next        = 1'b0;
                    node_index_next = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    // fetch the next node so its data is ready in the x step
                    i_next     = i_reg + ADDR_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = i_reg + ADDR_W'(1);
                    state_next = S_SQX;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            node_radius_reg <= '0;
            node_count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NODE_RADIUS: node_radius_reg <= cfg_data[RADIUS_W-1:0];
                    REG_NODE_COUNT:  node_count_reg  <= cfg_data[COUNT_W-1:0];
                    default:         node_count_reg  <= node_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        hit_reg        <= hit_next;
        node_index_reg <= node_index_next;
        if (accept)
        begin
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            rsum_reg <= RSUM_W'(probe_radius) + RSUM_W'(node_radius_reg);
        end
    end

endmodule

`default_nettype wire
